// ===== sv/mdag_pkg.sv =====
// Shared types, codes and pattern tables of the DMA address generator.
`default_nettype none

package mdag_pkg;

  // Channel count and index width
  localparam int CHANNELS = 8;
  localparam int CHAN_W   = 3;
  localparam logic [7:0] CHAN_MASK = 8'((1 << CHANNELS) - 1);

  // Request commands as they arrive on the input channel
  localparam logic [1:0] CMD_WRITE = 2'd0;
  localparam logic [1:0] CMD_START = 2'd1;
  localparam logic [1:0] CMD_STEP  = 2'd2;

  // Register indexes of a channel
  localparam logic [2:0] REG_CTRL   = 3'd0;
  localparam logic [2:0] REG_BPORT  = 3'd1;
  localparam logic [2:0] REG_A_LO   = 3'd2;
  localparam logic [2:0] REG_A_MID  = 3'd3;
  localparam logic [2:0] REG_A_BANK = 3'd4;
  localparam logic [2:0] REG_CNT_LO = 3'd5;
  localparam logic [2:0] REG_CNT_HI = 3'd6;

  // A address step codes (control bits 4..3)
  localparam logic [1:0] STEP_INC = 2'd0;
  localparam logic [1:0] STEP_DEC = 2'd2;

  // Highest transfer mode with a pattern
  localparam logic [2:0] MODE_MAX = 3'd4;

  // B-bus base address
  localparam logic [13:0] B_BASE = 14'h2100;

  // Queued request between front and back
  typedef struct packed {
    logic [1:0]        cmd;
    logic [CHAN_W-1:0] channel;
    logic [2:0]        reg_index;
    logic [7:0]        data;
  } qent_t;

  // Pattern length minus one for each mode
  function automatic logic [1:0] pat_mask(input logic [2:0] mode);
    logic [1:0] m;
    unique case (mode)
      3'd0:    m = 2'd0;
      3'd1:    m = 2'd1;
      3'd2:    m = 2'd1;
      3'd3:    m = 2'd3;
      3'd4:    m = 2'd3;
      default: m = 2'd0;
    endcase
    return m;
  endfunction

  // B address offset for a mode and pattern position
  function automatic logic [1:0] pat_off(input logic [2:0] mode, input logic [1:0] pos);
    logic [1:0] o;
    unique case (mode)
      3'd1:    o = {1'b0, pos[0]};
      3'd3:    o = {1'b0, pos[1]};
      3'd4:    o = pos;
      default: o = 2'd0;
    endcase
    return o;
  endfunction

endpackage

`default_nettype wire

// ===== sv/mdag_front.sv =====
// Front end: accepts requests, drops those without effect, queues the rest.
`default_nettype none

module mdag_front import mdag_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic [1:0]        in_cmd,
  input  wire logic [CHAN_W-1:0] in_channel,
  input  wire logic [2:0]        in_reg_index,
  input  wire logic [7:0]        in_data,
  output logic                   q_valid,
  output qent_t                  q_entry,
  input  wire logic              q_pop
);

  qent_t      mem_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       keep;
  logic       push;
  logic       pop;

  // Classify: keep only requests that change state or may produce a transfer
  always_comb begin
    keep = 1'b0;
    unique case (in_cmd)
      CMD_WRITE: keep = (in_reg_index <= REG_CNT_HI) &&
                        ({1'b0, in_channel} < 4'(CHANNELS));
      CMD_START: keep = (in_data != 8'd0);
      CMD_STEP:  keep = 1'b1;
      default:   keep = 1'b0;
    endcase
  end

  assign in_stall = cnt_r[1];
  assign push     = in_valid && !in_stall && keep;
  assign pop      = q_pop && q_valid;
  assign q_valid  = (cnt_r != 2'd0);
  assign q_entry  = mem_r[rd_ptr_r];

  // Advance pointers and fill count
  always_comb begin
    wr_ptr_nxt = wr_ptr_r ^ push;
    rd_ptr_nxt = rd_ptr_r ^ pop;
    cnt_nxt    = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Store the request payload
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= '{cmd: in_cmd, channel: in_channel,
                           reg_index: in_reg_index, data: in_data};
    end
  end

endmodule

`default_nettype wire

// ===== sv/mdag_back.sv =====
// Back end: channel registers, transfer sequencing and the result register.
`default_nettype none

module mdag_back import mdag_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              q_valid,
  input  wire qent_t             q_entry,
  output logic                   q_pop,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic [23:0]            out_a_address,
  output logic [13:0]            out_b_address,
  output logic                   out_b_to_a,
  output logic [CHAN_W-1:0]      out_from_channel,
  output logic                   out_channel_last,
  output logic                   out_all_done
);

  logic [7:0]  ctl_r   [CHANNELS], ctl_nxt   [CHANNELS];
  logic [7:0]  port_r  [CHANNELS], port_nxt  [CHANNELS];
  logic [23:0] addr_r  [CHANNELS], addr_nxt  [CHANNELS];
  logic [15:0] count_r [CHANNELS], count_nxt [CHANNELS];
  logic [7:0]  armed_r, armed_nxt;
  logic [1:0]  ppos_r, ppos_nxt;

  logic              ovalid_r, ovalid_nxt;
  logic [23:0]       oa_r, oa_nxt;
  logic [13:0]       ob_r, ob_nxt;
  logic              odir_r, odir_nxt;
  logic [CHAN_W-1:0] och_r, och_nxt;
  logic              olast_r, olast_nxt;
  logic              odone_r, odone_nxt;

  logic              go;
  logic [7:0]        run;
  logic [7:0]        start_run;
  logic [CHAN_W:0]   low_before;
  logic [CHAN_W:0]   low_run;
  logic [CHAN_W-1:0] sel;
  logic [7:0]        sel_ctl;
  logic [2:0]        sel_mode;
  logic [1:0]        sel_mask;
  logic [1:0]        pos;
  logic [23:0]       sel_addr;
  logic [15:0]       new_low;
  logic [15:0]       new_count;
  logic              last;
  logic [7:0]        armed_after;

  // Lowest set bit, top bit flags an empty mask
  function automatic logic [CHAN_W:0] lowest(input logic [7:0] m);
    logic [CHAN_W:0] r;
    r = {1'b1, {CHAN_W{1'b0}}};
    for (int i = CHANNELS - 1; i >= 0; i--) begin
      if (m[i]) r = {1'b0, CHAN_W'(i)};
    end
    return r;
  endfunction

  // Runnable channels: armed, count nonzero, mode with a pattern
  always_comb begin
    for (int i = 0; i < CHANNELS; i++) begin
      run[i]       = armed_r[i] && (count_r[i] != 16'd0) && (ctl_r[i][2:0] <= MODE_MAX);
      start_run[i] = q_entry.data[i] && (count_r[i] != 16'd0) &&
                     (ctl_r[i][2:0] <= MODE_MAX);
    end
    for (int i = CHANNELS; i < 8; i++) begin
      run[i]       = 1'b0;
      start_run[i] = 1'b0;
    end
    run       = run & CHAN_MASK;
    start_run = start_run & CHAN_MASK;
  end

  // Select the transfer channel and work out its byte
  always_comb begin
    low_before = lowest(armed_r & CHAN_MASK);
    low_run    = lowest(run);
    sel        = low_run[CHAN_W-1:0];
    sel_ctl    = ctl_r[sel];
    sel_mode   = sel_ctl[2:0];
    sel_mask   = pat_mask(sel_mode);
    pos        = (low_before == low_run) ? (ppos_r & sel_mask) : 2'd0;
    sel_addr   = addr_r[sel];
    unique case (sel_ctl[4:3])
      STEP_INC: new_low = sel_addr[15:0] + 16'd1;
      STEP_DEC: new_low = sel_addr[15:0] - 16'd1;
      default:  new_low = sel_addr[15:0];
    endcase
    new_count   = count_r[sel] - 16'd1;
    last        = (new_count == 16'd0);
    armed_after = run & ~(last ? (8'd1 << sel) : 8'd0);
  end

  assign go    = !ovalid_r || !out_stall;
  assign q_pop = go;

  // Next state of the channel registers and the sequencer
  always_comb begin
    for (int i = 0; i < CHANNELS; i++) begin
      ctl_nxt[i]   = ctl_r[i];
      port_nxt[i]  = port_r[i];
      addr_nxt[i]  = addr_r[i];
      count_nxt[i] = count_r[i];
    end
    armed_nxt  = armed_r;
    ppos_nxt   = ppos_r;
    ovalid_nxt = go ? 1'b0 : ovalid_r;
    oa_nxt     = oa_r;
    ob_nxt     = ob_r;
    odir_nxt   = odir_r;
    och_nxt    = och_r;
    olast_nxt  = olast_r;
    odone_nxt  = odone_r;
    if (go && q_valid) begin
      unique case (q_entry.cmd)
        CMD_WRITE: begin
          unique case (q_entry.reg_index)
            REG_CTRL:   ctl_nxt[q_entry.channel]         = q_entry.data;
            REG_BPORT:  port_nxt[q_entry.channel]        = q_entry.data;
            REG_A_LO:   addr_nxt[q_entry.channel][7:0]   = q_entry.data;
            REG_A_MID:  addr_nxt[q_entry.channel][15:8]  = q_entry.data;
            REG_A_BANK: addr_nxt[q_entry.channel][23:16] = q_entry.data;
            REG_CNT_LO: count_nxt[q_entry.channel][7:0]  = q_entry.data;
            REG_CNT_HI: count_nxt[q_entry.channel][15:8] = q_entry.data;
            default: ;
          endcase
        end
        CMD_START: begin
          armed_nxt = start_run;
          ppos_nxt  = 2'd0;
        end
        CMD_STEP: begin
          // Drop channels that cannot run, then move one byte
          armed_nxt = run;
          if (low_before != low_run) ppos_nxt = 2'd0;
          if (!low_run[CHAN_W]) begin
            addr_nxt[sel]  = {sel_addr[23:16], new_low};
            count_nxt[sel] = new_count;
            armed_nxt      = armed_after;
            ppos_nxt       = last ? 2'd0 : ((pos + 2'd1) & sel_mask);
            ovalid_nxt     = 1'b1;
            oa_nxt         = sel_addr;
            ob_nxt         = B_BASE + {6'd0, port_r[sel]} + {12'd0, pat_off(sel_mode, pos)};
            odir_nxt       = sel_ctl[7];
            och_nxt        = sel;
            olast_nxt      = last;
            odone_nxt      = (armed_after == 8'd0);
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < CHANNELS; i++) begin
        ctl_r[i]   <= 8'd0;
        port_r[i]  <= 8'd0;
        addr_r[i]  <= 24'd0;
        count_r[i] <= 16'd0;
      end
      armed_r  <= 8'd0;
      ppos_r   <= 2'd0;
      ovalid_r <= 1'b0;
    end else begin
      for (int i = 0; i < CHANNELS; i++) begin
        ctl_r[i]   <= ctl_nxt[i];
        port_r[i]  <= port_nxt[i];
        addr_r[i]  <= addr_nxt[i];
        count_r[i] <= count_nxt[i];
      end
      armed_r  <= armed_nxt;
      ppos_r   <= ppos_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end

  // Hold the result payload
  always_ff @(posedge clk) begin
    oa_r    <= oa_nxt;
    ob_r    <= ob_nxt;
    odir_r  <= odir_nxt;
    och_r   <= och_nxt;
    olast_r <= olast_nxt;
    odone_r <= odone_nxt;
  end

  assign out_valid        = ovalid_r;
  assign out_a_address    = oa_r;
  assign out_b_address    = ob_r;
  assign out_b_to_a       = odir_r;
  assign out_from_channel = och_r;
  assign out_channel_last = olast_r;
  assign out_all_done     = odone_r;

endmodule

`default_nettype wire

// ===== sv/multichannel_dma_address_generator_top.sv =====
// Top level of the eight-channel DMA address generator.
//
//   channel | direction | handshake          | payload
//   in_     | input     | in_valid/in_stall  | cmd, channel, reg_index, data
//   out_    | output    | out_valid/out_stall| a_address, b_address, b_to_a,
//           |           |                    | from_channel, channel_last, all_done
//
// One request per cycle is taken into a two-entry queue while in_stall is low; the
// back end takes it when out_stall does not hold a result, so a step's transfer
// passes from the queue entry into the output register.
// The back end executes one request per cycle unless out_stall holds a valid result,
// set by the single channel select and count update on the step path.
// Synchronous active-low reset clears all channel registers, the armed mask
// and the queue; no clearing pass is needed.
// in_stall rises only when the queue is full; out_stall holds the result.
`default_nettype none

module multichannel_dma_address_generator_top import mdag_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic [1:0]        in_cmd,
  input  wire logic [CHAN_W-1:0] in_channel,
  input  wire logic [2:0]        in_reg_index,
  input  wire logic [7:0]        in_data,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic [23:0]            out_a_address,
  output logic [13:0]            out_b_address,
  output logic                   out_b_to_a,
  output logic [CHAN_W-1:0]      out_from_channel,
  output logic                   out_channel_last,
  output logic                   out_all_done
);

  logic  q_valid;
  qent_t q_entry;
  logic  q_pop;

  mdag_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_cmd       (in_cmd),
    .in_channel   (in_channel),
    .in_reg_index (in_reg_index),
    .in_data      (in_data),
    .q_valid      (q_valid),
    .q_entry      (q_entry),
    .q_pop        (q_pop)
  );

  mdag_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .q_valid          (q_valid),
    .q_entry          (q_entry),
    .q_pop            (q_pop),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_a_address    (out_a_address),
    .out_b_address    (out_b_address),
    .out_b_to_a       (out_b_to_a),
    .out_from_channel (out_from_channel),
    .out_channel_last (out_channel_last),
    .out_all_done     (out_all_done)
  );

endmodule

`default_nettype wire
